[sv/prst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prst_pkg: shared types and constants of the point-add range-sum tree.
// Holds the field widths, request codes, controller states and the command
// and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package prst_pkg;

    localparam int DEF_POSITIONS = 1024;

    localparam int IN_IDX_W = 10;
    localparam int DELTA_W  = 32;
    localparam int SUM_W    = 64;
    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 64;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUM = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_STEP,
        ST_SUM_DONE
    } state_t;

    typedef struct packed {
        logic load;        // latch a request and set up the walk
        logic clr;         // write zero at the clear counter, advance it
        logic add_rd;      // read the current node of an add walk
        logic add_wr;      // write node plus delta back, move to parent
        logic sum_take_a;  // read node a, step a to the right
        logic sum_take_b;  // read node b-1, add it if b is odd, then halve a and b
        logic out_load;    // move the finished total to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;    // clear counter at the last node
        logic node_zero;   // add walk finished or position out of range
        logic a_lt_b;      // range walk still has nodes to visit
        logic a_odd;
        logic out_free;    // output register can take a new total
    } dp_stat_t;

endpackage

[sv/prst_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prst_dp: datapath of the point-add range-sum tree.
// Holds the node memory, the walk pointers, the running total and the
// output register; acts only on commands from the controller.
// ----------------------------------------------------------------------------
module prst_dp #(
    parameter int POSITIONS = prst_pkg::DEF_POSITIONS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  prst_pkg::dp_cmd_t                    cmd,
    input  logic [prst_pkg::IN_IDX_W-1:0]        in_first,
    input  logic [prst_pkg::IN_IDX_W-1:0]        in_last,
    input  logic signed [prst_pkg::DELTA_W-1:0]  in_delta,
    input  logic                                 m_tready,
    output prst_pkg::dp_stat_t                   stat,
    output logic                                 m_tvalid,
    output logic [prst_pkg::SUM_W-1:0]           m_tdata
);

    localparam int NODES  = 2 * POSITIONS;
    localparam int NODE_W = $clog2(NODES);
    localparam int IDX_W  = $clog2(NODES + 1);
    localparam int CMP_W  = (IDX_W > prst_pkg::IN_IDX_W) ? IDX_W : prst_pkg::IN_IDX_W;
    localparam logic [CMP_W-1:0]  POS_C     = CMP_W'(POSITIONS);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    logic [prst_pkg::SUM_W-1:0] node_mem [0:NODES-1];

    logic [prst_pkg::SUM_W-1:0]         rd_data_reg;
    logic [NODE_W-1:0]                  rd_addr;
    logic                               wr_en;
    logic [NODE_W-1:0]                  wr_addr;
    logic [prst_pkg::SUM_W-1:0]         wr_data;

    logic [NODE_W-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]                  node_reg, node_next;
    logic [IDX_W-1:0]                   a_reg, a_next;
    logic [IDX_W-1:0]                   b_reg, b_next;
    logic [IDX_W-1:0]                   b_dec;
    logic signed [prst_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [prst_pkg::SUM_W-1:0]         total_reg, total_next;
    logic                               acc_pend_reg, acc_pend_next;
    logic                               out_valid_reg, out_valid_next;
    logic [prst_pkg::SUM_W-1:0]         out_data_reg, out_data_next;

    logic [CMP_W-1:0] first_ext, last_ext, hi_clamp;
    logic             lo_ok, empty;

    // Request decode: clamp the high end and spot empty ranges.
    always_comb begin
        first_ext = CMP_W'(in_first);
        last_ext  = CMP_W'(in_last);
        lo_ok     = first_ext < POS_C;
        hi_clamp  = (last_ext >= POS_C) ? (POS_C - CMP_W'(1)) : last_ext;
        empty     = !lo_ok || (first_ext > hi_clamp);
    end

    assign b_dec = b_reg - IDX_W'(1);

    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        node_next      = node_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        delta_next     = delta_reg;
        total_next     = total_reg;
        acc_pend_next  = 1'b0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_addr        = node_reg;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = rd_data_reg + {{(prst_pkg::SUM_W - prst_pkg::DELTA_W){delta_reg[
                         prst_pkg::DELTA_W-1]}}, delta_reg};

        if (acc_pend_reg) begin
            total_next = total_reg + rd_data_reg;
        end

        if (cmd.clr) begin
            wr_en        = 1'b1;
            wr_addr      = clr_cnt_reg;
            wr_data      = '0;
            clr_cnt_next = clr_cnt_reg + NODE_W'(1);
        end

        if (cmd.load) begin
            delta_next    = in_delta;
            total_next    = '0;
            node_next     = lo_ok ? (NODE_W'(first_ext) + NODE_W'(POSITIONS)) : '0;
            if (empty) begin
                a_next = '0;
                b_next = '0;
            end else begin
                a_next = IDX_W'(first_ext) + IDX_W'(POSITIONS);
                b_next = IDX_W'(hi_clamp) + IDX_W'(POSITIONS) + IDX_W'(1);
            end
        end

        if (cmd.add_rd) begin
            rd_addr = node_reg;
        end

        if (cmd.add_wr) begin
            wr_en     = 1'b1;
            node_next = node_reg >> 1;
        end

        if (cmd.sum_take_a) begin
            rd_addr       = a_reg[NODE_W-1:0];
            acc_pend_next = 1'b1;
            a_next        = a_reg + IDX_W'(1);
        end

        if (cmd.sum_take_b) begin
            rd_addr       = b_dec[NODE_W-1:0];
            acc_pend_next = b_reg[0];
            a_next        = a_reg >> 1;
            b_next        = b_reg >> 1;
        end

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg   <= clr_cnt_next;
            acc_pend_reg  <= acc_pend_next;
            out_valid_reg <= out_valid_next;
        end
        node_reg     <= node_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        delta_reg    <= delta_next;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        stat.clr_last  = clr_cnt_reg == LAST_NODE;
        stat.node_zero = node_reg == '0;
        stat.a_lt_b    = a_reg < b_reg;
        stat.a_odd     = a_reg[0];
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/prst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prst_ctrl: controller of the point-add range-sum tree.
// Sequences the clearing pass, the leaf-to-root add walk and the
// two-pointer range walk, and drives the input handshake.
// ----------------------------------------------------------------------------
module prst_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 req_type,
    input  prst_pkg::dp_stat_t   stat,
    output logic                 s_tready,
    output prst_pkg::dp_cmd_t    cmd
);

    prst_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prst_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            prst_pkg::ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = prst_pkg::ST_IDLE;
                end
            end
            prst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (req_type == prst_pkg::REQ_SUM) ?
                                 prst_pkg::ST_SUM_STEP : prst_pkg::ST_ADD_RD;
                end
            end
            prst_pkg::ST_ADD_RD: begin
                if (stat.node_zero) begin
                    state_next = prst_pkg::ST_IDLE;
                end else begin
                    cmd.add_rd = 1'b1;
                    state_next = prst_pkg::ST_ADD_WR;
                end
            end
            prst_pkg::ST_ADD_WR: begin
                cmd.add_wr = 1'b1;
                state_next = prst_pkg::ST_ADD_RD;
            end
            prst_pkg::ST_SUM_STEP: begin
                if (!stat.a_lt_b) begin
                    state_next = prst_pkg::ST_SUM_DONE;
                end else if (stat.a_odd) begin
                    cmd.sum_take_a = 1'b1;
                end else begin
                    cmd.sum_take_b = 1'b1;
                end
            end
            prst_pkg::ST_SUM_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = prst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = prst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/point_add_range_sum_tree_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_add_range_sum_tree_core: segment tree with point add and range sum.
// Keeps 64-bit wrapping node sums over POSITIONS positions in one memory and
// answers inclusive range sums; adds give no result beat.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                         | tuser
//  --------+-----------+--------------------------------------------+-----------
//  s_      | in        | first_index[9:0], last_index[9:0],         | req_type
//          |           | delta[31:0] signed, 4 zero pad bits        | (0 add,
//          |           |                                            |  1 sum)
//  m_      | out       | range_total[63:0] signed                   | none
//
// After reset a clearing pass zeroes all 2*POSITIONS nodes (2048 by default)
// with s_tready low. An add reads and writes one node per level, leaf to root.
// A range sum reads one or two nodes per level on its way up. One request is
// in work at a time; a finished total waits in the output register, and a
// second one holds the block until that register frees.
//
module point_add_range_sum_tree_core #(
    parameter int POSITIONS = prst_pkg::DEF_POSITIONS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: first_index[9:0], last_index[19:10], delta[51:20], zero pad
    input  logic [prst_pkg::TDATA_IN_W-1:0]     s_tdata,
    // s_tuser: req_type
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: range_total[63:0]
    output logic [prst_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    prst_pkg::dp_cmd_t  cmd;
    prst_pkg::dp_stat_t stat;

    logic [prst_pkg::IN_IDX_W-1:0]        first_index;
    logic [prst_pkg::IN_IDX_W-1:0]        last_index;
    logic signed [prst_pkg::DELTA_W-1:0]  delta;

    // Unpack the request beat; the pad bits above delta carry nothing.
    assign first_index = s_tdata[prst_pkg::IN_IDX_W-1:0];
    assign last_index  = s_tdata[2*prst_pkg::IN_IDX_W-1:prst_pkg::IN_IDX_W];
    assign delta       = s_tdata[2*prst_pkg::IN_IDX_W+prst_pkg::DELTA_W-1:
                                 2*prst_pkg::IN_IDX_W];

    prst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    prst_dp #(
        .POSITIONS (POSITIONS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_first (first_index),
        .in_last  (last_index),
        .in_delta (delta),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
